// ----- design/dspm_pkg.sv -----
package dspm_pkg;

  // Fraction bits of every Q-format value in the block.
  localparam int FRAC_BITS = 16;

  // Offset from the center: pixel << FRAC_BITS or depth, minus a 32-bit center.
  localparam int OFF_W  = ((16 + FRAC_BITS > 32) ? (16 + FRAC_BITS) : 32) + 1;
  // Dividend of an axis division: offset magnitude << FRAC_BITS.
  localparam int NUM_W  = OFF_W + FRAC_BITS;
  // Width of the saturation compare of an axis division.
  localparam int SATC_W = OFF_W + 31;
  // Channel magnitude times matte.
  localparam int CPROD_W = 33 + FRAC_BITS;

  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [30:0]        DMAX   = '1;

  // Pipeline stage numbers.
  localparam int S_OFF   = 1;
  localparam int S_MAG   = 2;
  localparam int S_DPRE  = 3;
  localparam int S_DIV0  = 4;
  localparam int S_DSAT  = S_DIV0 + 31;
  localparam int S_SQ    = S_DSAT + 1;
  localparam int S_RAD   = S_SQ + 1;
  localparam int S_RT0   = S_RAD + 1;
  localparam int S_DIST  = S_RT0 + 32;
  localparam int S_DM1   = S_DIST + 1;
  localparam int S_PROD  = S_DM1 + 1;
  localparam int S_RPRE  = S_PROD + 1;
  localparam int S_RD0   = S_RPRE + 1;
  localparam int S_MATTE = S_RD0 + FRAC_BITS;
  localparam int S_CMUL  = S_MATTE + 1;
  localparam int S_OUT   = S_CMUL + 1;
  localparam int NSTG    = S_OUT + 1;

  // Rescaling of the matte to 16 fraction bits.
  localparam int MV_DN  = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
  localparam int MV_UP  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
  localparam int MV_RND = (MV_DN > 0) ? (1 << (MV_DN - 1)) : 0;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_CENTER_Z = 3'd3,
    REG_SIZE_X   = 3'd4,
    REG_SIZE_Y   = 3'd5,
    REG_SIZE_Z   = 3'd6,
    REG_FALLOFF  = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] SHAPE_CUBE = 2'd1;
  localparam logic [1:0] SHAPE_CYL  = 2'd2;

  typedef struct packed {
    logic [2:0]             mode;
    logic [2:0][31:0]       center;
    logic [2:0][30:0]       size;
    logic [30:0]            falloff;
    logic [30:0]            avg;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  rem;
    logic [34:0] quo;
    logic [34:0] num;
  } div3_t;

  typedef struct packed {
    logic [15:0]             pos_x;
    logic [15:0]             pos_y;
    logic [31:0]             depth;
    logic [3:0][31:0]        chan;
    logic [3:0]              neg;
    logic [2:0][OFF_W-1:0]   off;
    logic [2:0][NUM_W-1:0]   num;
    logic [2:0][30:0]        rem;
    logic [2:0][30:0]        quo;
    logic [2:0]              sat;
    logic [2:0][61:0]        sq;
    logic [63:0]             rad;
    logic [33:0]             rrem;
    logic [31:0]             root;
    logic [30:0]             dnorm;
    logic                    in_shape;
    logic [30:0]             dm1;
    logic [61:0]             prod;
    logic                    big;
    logic [30:0]             frem;
    logic [FRAC_BITS-1:0]    ramp;
    logic [FRAC_BITS:0]      matte;
    logic [3:0][CPROD_W-1:0] cprod;
  } pl_t;

endpackage

// ----- design/deep_sample_position_matte_top.sv -----
// Deep sample position matte. Each transaction on the in_ channel carries one deep
// sample (pixel column and row, Q16.16 depth and premultiplied RGBA); the block
// returns one transaction on the out_ channel with the RGBA scaled by a matte and
// the matte itself in Q1.16. The matte is one inside an ellipsoid, box or Y-axis
// cylinder around the configured center and, with a nonzero falloff, ramps to zero
// outside it; mode bit 2 inverts it. The block is a fully pipelined datapath that
// accepts one sample every clock while the output is not stalled. Its longest
// sections are the bit-per-stage axis dividers (31 stages), the square-root
// pipeline (32 stages) and the falloff divider (16 stages). The pipeline moves
// as a whole: it stalls only while a finished result is held unaccepted at the
// output. Configuration writes are always accepted (cfg_ready is tied high) but
// must only be issued while no sample is in flight; an internal divide-by-three
// of the size sum is registered, so the average lags a size write.
module deep_sample_position_matte_top
  import dspm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pos_x,
  input  logic [15:0] in_pos_y,
  input  logic [31:0] in_depth,
  input  logic [31:0] in_red,
  input  logic [31:0] in_green,
  input  logic [31:0] in_blue,
  input  logic [31:0] in_alpha,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_red,
  output logic [31:0] out_green,
  output logic [31:0] out_blue,
  output logic [31:0] out_alpha,
  output logic [16:0] out_matte_value
);

  // Configuration registers.
  logic [2:0]  mode_r;
  logic [31:0] center_x_r, center_y_r, center_z_r;
  logic [30:0] size_x_r, size_y_r, size_z_r;
  logic [30:0] falloff_r;

  // Size average pipeline: long division of the size sum by three, seven bits a stage.
  div3_t [4:0] avg_r;
  div3_t [4:0] avg_nxt;
  div3_t       avg_src;

  cfg_t        cfgv;

  // Datapath pipeline: one struct per stage, valid bits alongside.
  pl_t [NSTG-1:0]  pipe_r;
  pl_t [NSTG-1:0]  pipe_nxt;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic            adv;

  logic [31:0]     mv_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 3'd0;
      center_x_r <= 32'(64'd960 << FRAC_BITS);
      center_y_r <= 32'(64'd540 << FRAC_BITS);
      center_z_r <= 32'(64'd50 << FRAC_BITS);
      size_x_r   <= 31'(64'd100 << FRAC_BITS);
      size_y_r   <= 31'(64'd100 << FRAC_BITS);
      size_z_r   <= 31'(64'd50 << FRAC_BITS);
      falloff_r  <= 31'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:     mode_r     <= cfg_data[2:0];
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        REG_CENTER_Z: center_z_r <= cfg_data;
        REG_SIZE_X:   size_x_r   <= cfg_data[30:0];
        REG_SIZE_Y:   size_y_r   <= cfg_data[30:0];
        REG_SIZE_Z:   size_z_r   <= cfg_data[30:0];
        REG_FALLOFF:  falloff_r  <= cfg_data[30:0];
        default:      mode_r     <= mode_r;
      endcase
    end
  end

  // A zero size acts as one LSB.
  always_comb begin
    cfgv.mode      = mode_r;
    cfgv.center[0] = center_x_r;
    cfgv.center[1] = center_y_r;
    cfgv.center[2] = center_z_r;
    cfgv.size[0]   = (size_x_r == '0) ? 31'd1 : size_x_r;
    cfgv.size[1]   = (size_y_r == '0) ? 31'd1 : size_y_r;
    cfgv.size[2]   = (size_z_r == '0) ? 31'd1 : size_z_r;
    cfgv.falloff   = falloff_r;
    cfgv.avg       = avg_r[4].quo[30:0];
  end

  function automatic div3_t div3_chunk(input div3_t a, input int s);
    div3_t      n;
    logic [2:0] t;
    int         b;
    n = a;
    for (int j = 0; j < 7; j++) begin
      b = 34 - 7 * s - j;
      t = {n.rem, n.num[b]};
      if (t >= 3'd3) begin
        n.rem    = 2'(t - 3'd3);
        n.quo[b] = 1'b1;
      end else begin
        n.rem = t[1:0];
      end
    end
    return n;
  endfunction

  always_comb begin
    avg_src.rem = 2'd0;
    avg_src.quo = '0;
    avg_src.num = 35'(cfgv.size[0]) + 35'(cfgv.size[1]) + 35'(cfgv.size[2]);
    avg_nxt[0]  = div3_chunk(avg_src, 0);
    for (int s = 1; s < 5; s++) begin
      avg_nxt[s] = div3_chunk(avg_r[s-1], s);
    end
  end

  always_ff @(posedge clk) begin
    avg_r <= avg_nxt;
  end

  // Work of pipeline stage k on the item leaving stage k-1.
  function automatic pl_t stage_fn(input int k, input pl_t p, input cfg_t c);
    pl_t                 n;
    logic [NUM_W-1:0]    nm;
    logic [31:0]         t;
    logic [35:0]         rt;
    logic [35:0]         tr;
    logic [30:0]         rs;
    logic [30:0]         mx;
    logic [FRAC_BITS:0]  m;
    logic [31:0]         r;
    int                  b;
    n = p;
    if (k == S_OFF) begin
      n.off[0] = ({{(OFF_W-16){p.pos_x[15]}}, p.pos_x} << FRAC_BITS)
               - {{(OFF_W-32){c.center[0][31]}}, c.center[0]};
      n.off[1] = ({{(OFF_W-16){p.pos_y[15]}}, p.pos_y} << FRAC_BITS)
               - {{(OFF_W-32){c.center[1][31]}}, c.center[1]};
      n.off[2] = {{(OFF_W-32){p.depth[31]}}, p.depth}
               - {{(OFF_W-32){c.center[2][31]}}, c.center[2]};
    end else if (k == S_MAG) begin
      for (int i = 0; i < 3; i++) begin
        n.off[i] = p.off[i][OFF_W-1] ? -p.off[i] : p.off[i];
      end
    end else if (k == S_DPRE) begin
      // The quotient saturates exactly when the magnitude reaches size << (31 - F).
      for (int i = 0; i < 3; i++) begin
        nm       = NUM_W'(p.off[i]) << FRAC_BITS;
        n.num[i] = nm;
        n.sat[i] = SATC_W'(p.off[i]) >= (SATC_W'(c.size[i]) << (31 - FRAC_BITS));
        n.rem[i] = 31'(nm >> 31);
        n.quo[i] = '0;
      end
    end else if (k >= S_DIV0 && k < S_DSAT) begin
      b = 30 - (k - S_DIV0);
      for (int i = 0; i < 3; i++) begin
        t = {p.rem[i], p.num[i][b]};
        if (t >= {1'b0, c.size[i]}) begin
          n.rem[i]    = 31'(t - {1'b0, c.size[i]});
          n.quo[i][b] = 1'b1;
        end else begin
          n.rem[i] = t[30:0];
        end
      end
    end else if (k == S_DSAT) begin
      for (int i = 0; i < 3; i++) begin
        if (p.sat[i]) begin
          n.quo[i] = DMAX;
        end
      end
    end else if (k == S_SQ) begin
      for (int i = 0; i < 3; i++) begin
        n.sq[i] = 62'(p.quo[i]) * 62'(p.quo[i]);
      end
    end else if (k == S_RAD) begin
      if (c.mode[1:0] == SHAPE_CYL) begin
        n.rad = 64'(p.sq[0]) + 64'(p.sq[2]);
      end else begin
        n.rad = 64'(p.sq[0]) + 64'(p.sq[1]) + 64'(p.sq[2]);
      end
      n.rrem = '0;
      n.root = '0;
    end else if (k >= S_RT0 && k < S_DIST) begin
      b  = 31 - (k - S_RT0);
      rt = {p.rrem, p.rad[2*b+1 -: 2]};
      tr = {2'b00, p.root, 2'b01};
      if (rt >= tr) begin
        n.rrem = 34'(rt - tr);
        n.root = {p.root[30:0], 1'b1};
      end else begin
        n.rrem = rt[33:0];
        n.root = {p.root[30:0], 1'b0};
      end
    end else if (k == S_DIST) begin
      rs = (p.root > 32'(DMAX)) ? DMAX : p.root[30:0];
      priority if (c.mode[1:0] == SHAPE_CUBE) begin
        mx = (p.quo[0] > p.quo[1]) ? p.quo[0] : p.quo[1];
        n.dnorm = (p.quo[2] > mx) ? p.quo[2] : mx;
      end else if (c.mode[1:0] == SHAPE_CYL) begin
        n.dnorm = (p.quo[1] > rs) ? p.quo[1] : rs;
      end else begin
        n.dnorm = rs;
      end
    end else if (k == S_DM1) begin
      n.in_shape = p.dnorm <= 31'(ONE_FX);
      n.dm1      = p.dnorm - 31'(ONE_FX);
    end else if (k == S_PROD) begin
      n.prod = 62'(p.dm1) * 62'(c.avg);
    end else if (k == S_RPRE) begin
      // With zero falloff this flag is always set, which gives the hard edge.
      n.big  = p.prod >= (62'(c.falloff) << FRAC_BITS);
      n.frem = 31'(p.prod >> FRAC_BITS);
      n.ramp = '0;
    end else if (k >= S_RD0 && k < S_MATTE) begin
      b = FRAC_BITS - 1 - (k - S_RD0);
      t = {p.frem, p.prod[b]};
      if (t >= {1'b0, c.falloff}) begin
        n.frem    = 31'(t - {1'b0, c.falloff});
        n.ramp[b] = 1'b1;
      end else begin
        n.frem = t[30:0];
      end
    end else if (k == S_MATTE) begin
      priority if (p.in_shape) begin
        m = ONE_FX;
      end else if (p.big) begin
        m = '0;
      end else begin
        m = ONE_FX - {1'b0, p.ramp};
      end
      n.matte = c.mode[2] ? (ONE_FX - m) : m;
      for (int ch = 0; ch < 4; ch++) begin
        n.neg[ch]  = p.chan[ch][31];
        n.chan[ch] = p.chan[ch][31] ? -p.chan[ch] : p.chan[ch];
      end
    end else if (k == S_CMUL) begin
      for (int ch = 0; ch < 4; ch++) begin
        n.cprod[ch] = CPROD_W'(p.chan[ch]) * CPROD_W'(p.matte);
      end
    end else if (k == S_OUT) begin
      for (int ch = 0; ch < 4; ch++) begin
        r = 32'((p.cprod[ch] + CPROD_W'(ONE_FX >> 1)) >> FRAC_BITS);
        n.chan[ch] = p.neg[ch] ? -r : r;
      end
    end
    return n;
  endfunction

  // The whole pipeline advances unless a finished result is waiting at the output.
  assign adv      = !vld_r[NSTG-1] || out_ready;
  assign in_ready = adv;

  always_comb begin
    pipe_nxt[0]         = '0;
    pipe_nxt[0].pos_x   = in_pos_x;
    pipe_nxt[0].pos_y   = in_pos_y;
    pipe_nxt[0].depth   = in_depth;
    pipe_nxt[0].chan[0] = in_red;
    pipe_nxt[0].chan[1] = in_green;
    pipe_nxt[0].chan[2] = in_blue;
    pipe_nxt[0].chan[3] = in_alpha;
    for (int k = 1; k < NSTG; k++) begin
      pipe_nxt[k] = stage_fn(k, pipe_r[k-1], cfgv);
    end
    vld_nxt = {vld_r[NSTG-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  // Matte rescaled to 16 fraction bits.
  assign mv_wide = ((32'(pipe_r[NSTG-1].matte) + 32'(MV_RND)) >> MV_DN) << MV_UP;

  assign out_valid       = vld_r[NSTG-1];
  assign out_red         = pipe_r[NSTG-1].chan[0];
  assign out_green       = pipe_r[NSTG-1].chan[1];
  assign out_blue        = pipe_r[NSTG-1].chan[2];
  assign out_alpha       = pipe_r[NSTG-1].chan[3];
  assign out_matte_value = mv_wide[16:0];

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the deep sample position matte. Samples are streamed
// through the valid/ready channels with random gaps on both sides, the matte
// predictor computes each expected result at input acceptance, and the
// scoreboard compares results in order.
module testbench;
  import dspm_pkg::*;

  typedef struct {
    logic [31:0] red, green, blue, alpha;
    logic [16:0] matte;
  } matte_result_t;

  // Holds the expected results of accepted samples, oldest first.
  class matte_scoreboard;
    matte_result_t pending[$];
    int mismatches;
    int errors;

    function void note_sample(matte_result_t r);
      pending = {pending, r};
    endfunction

    function void check_result(matte_result_t got);
      matte_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("ERROR: result with nothing pending");
        return;
      end
      exp_r = pending.pop_front();
      if (got.red !== exp_r.red || got.green !== exp_r.green || got.blue !== exp_r.blue ||
          got.alpha !== exp_r.alpha || got.matte !== exp_r.matte) begin
        mismatches++;
        errors++;
        if (mismatches <= 10)
          $display("MISMATCH exp r=%h g=%h b=%h a=%h m=%h got r=%h g=%h b=%h a=%h m=%h",
                   exp_r.red, exp_r.green, exp_r.blue, exp_r.alpha, exp_r.matte,
                   got.red, got.green, got.blue, got.alpha, got.matte);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_pos_x = '0, in_pos_y = '0;
  logic [31:0] in_depth = '0, in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_red, out_green, out_blue, out_alpha;
  logic [16:0] out_matte_value;

  // Local copy of the configuration registers, kept in step with every write.
  logic [2:0] mode_q;
  logic [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] half_x, half_y, half_z, soft_w;

  matte_scoreboard sb;
  bit no_out_gaps = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  deep_sample_position_matte_top DUT (.*);

  // Integer square root, floor, bit by bit.
  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalized axis distance: |offset| << F / size, saturated at the Q16.16 max.
  function automatic logic [63:0] axis_norm(longint off, logic [63:0] size);
    logic [63:0] mag, q;
    mag = (off < 0) ? -off : off;
    q = (mag << FRAC_BITS) / size;
    return (q > 64'h7FFFFFFF) ? 64'h7FFFFFFF : q;
  endfunction

  // Rounded magnitude scaling of a signed channel by the matte.
  function automatic logic [31:0] apply_matte(logic [31:0] raw, logic [63:0] m);
    longint c;
    logic [63:0] mag, r;
    c = longint'(signed'(raw));
    mag = (c < 0) ? -c : c;
    r = (mag * m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (c < 0) r = -r;
    return r[31:0];
  endfunction

  function automatic matte_result_t predict_matte(logic [15:0] px, logic [15:0] py,
      logic [31:0] pz, logic [31:0] r, logic [31:0] g, logic [31:0] b, logic [31:0] a);
    matte_result_t res;
    logic [63:0] sx, sy, sz, dx, dy, dz, dnorm, matte, avg, ramp, one;
    one = 64'd1 << FRAC_BITS;
    sx = (half_x == 0) ? 64'd1 : 64'(half_x);
    sy = (half_y == 0) ? 64'd1 : 64'(half_y);
    sz = (half_z == 0) ? 64'd1 : 64'(half_z);
    dx = axis_norm(longint'(signed'(px)) * (1 << FRAC_BITS) - longint'(signed'(ctr_x)), sx);
    dy = axis_norm(longint'(signed'(py)) * (1 << FRAC_BITS) - longint'(signed'(ctr_y)), sy);
    dz = axis_norm(longint'(signed'(pz)) - longint'(signed'(ctr_z)), sz);
    if (mode_q[1:0] == SHAPE_CUBE) begin
      dnorm = (dx > dy) ? dx : dy;
      if (dz > dnorm) dnorm = dz;
    end else if (mode_q[1:0] == SHAPE_CYL) begin
      dnorm = int_root(dx * dx + dz * dz);
      if (dy > dnorm) dnorm = dy;
    end else begin
      dnorm = int_root(dx * dx + dy * dy + dz * dz);
    end
    if (dnorm > 64'h7FFFFFFF) dnorm = 64'h7FFFFFFF;
    if (dnorm <= one) begin
      matte = one;
    end else if (soft_w != 0) begin
      avg = (sx + sy + sz) / 3;
      ramp = ((dnorm - one) * avg) / soft_w;
      matte = (ramp >= one) ? 64'd0 : one - ramp;
    end else begin
      matte = 0;
    end
    if (mode_q[2]) matte = one - matte;
    res.red = apply_matte(r, matte);
    res.green = apply_matte(g, matte);
    res.blue = apply_matte(b, matte);
    res.alpha = apply_matte(a, matte);
    res.matte = matte[16:0];
    return res;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE: mode_q = value[2:0];
      REG_CENTER_X: ctr_x = value;
      REG_CENTER_Y: ctr_y = value;
      REG_CENTER_Z: ctr_z = value;
      REG_SIZE_X: half_x = value[30:0];
      REG_SIZE_Y: half_y = value[30:0];
      REG_SIZE_Z: half_z = value[30:0];
      REG_FALLOFF: soft_w = value[30:0];
      default: ;
    endcase
  endtask

  // Sends one sample, predicting its result at acceptance. Valid drops only when a
  // gap follows; with no gap the next sample is presented at the accepting edge.
  task automatic send_sample(logic [15:0] px, logic [15:0] py, logic [31:0] pz,
      logic [31:0] r, logic [31:0] g, logic [31:0] b, logic [31:0] a);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_depth <= pz;
    in_red <= r; in_green <= g; in_blue <= b; in_alpha <= a;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(predict_matte(px, py, pz, r, g, b, a));
  endtask

  // Waits until every expected result is back, then lets the pipeline and the
  // divide-by-three of the size sum settle before the next register write.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // A random sample placed mostly near the current center so that inside,
  // ramp and outside regions are all reached; some samples are pure noise.
  task automatic send_random_sample();
    logic [15:0] px, py;
    logic [31:0] pz;
    int spread;
    spread = $urandom_range(1, 400);
    if ($urandom_range(0, 4) == 0) begin
      px = 16'($urandom); py = 16'($urandom); pz = $urandom;
    end else begin
      px = 16'(ctr_x[31:16] + $urandom_range(0, 2 * spread) - spread);
      py = 16'(ctr_y[31:16] + $urandom_range(0, 2 * spread) - spread);
      pz = ctr_z + ($urandom_range(0, 2 * spread) - spread) * 32'sd16384;
    end
    send_sample(px, py, pz, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Random output back-pressure, with stall-free stretches.
  always @(posedge clk) begin
    if (no_out_gaps || $urandom_range(0, 10) < 4) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 10) == 0);
  end

  // Results are taken at the edge where valid and ready are both high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_red, out_green, out_blue, out_alpha, out_matte_value});
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    sb = new();
    mode_q = 3'd0;
    ctr_x = 32'd960 << 16; ctr_y = 32'd540 << 16; ctr_z = 32'd50 << 16;
    half_x = 31'd100 << 16; half_y = 31'd100 << 16; half_z = 31'd50 << 16;
    soft_w = 31'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (10) @(posedge clk);

    // Directed part on reset settings: center, far corners, extremes of colors.
    send_sample(16'd960, 16'd540, 32'd50 << 16, 32'h7FFFFFFF, 32'h80000000, 32'd1, 32'hFFFFFFFF);
    send_sample(16'h7FFF, 16'h8000, 32'h80000000, 32'h12345678, 32'h0, 32'h10000, 32'h7FFFFFFF);
    send_sample(16'h8000, 16'h7FFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h80000000, 32'h0);
    send_sample(16'd1060, 16'd540, 32'd50 << 16, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_sample(16'd1061, 16'd540, 32'd50 << 16, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    drain_block();

    // Soft edge, cube, cylinder, shape code three and inverted matte.
    write_reg(REG_FALLOFF, 32'd50 << 16);
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_MODE, s);
      send_sample(16'd1000, 16'd600, 32'd70 << 16, 32'h7FFFFFFF, 32'h80000001, 32'h8000, 32'hFFFF8000);
      send_sample(16'd1070, 16'd540, 32'd50 << 16, 32'h10000, 32'hFFFF0000, 32'h3, 32'h10001);
      drain_block();
    end

    // Zero sizes (one LSB), then the largest sizes and falloff, with extreme centers.
    write_reg(REG_SIZE_X, 32'd0); write_reg(REG_SIZE_Y, 32'd0); write_reg(REG_SIZE_Z, 32'd0);
    write_reg(REG_CENTER_X, 32'h80000000); write_reg(REG_CENTER_Y, 32'h7FFFFFFF);
    write_reg(REG_CENTER_Z, 32'h0);
    send_sample(16'h8000, 16'h7FFF, 32'h0, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_sample(16'h0, 16'h0, 32'h1, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    drain_block();
    write_reg(REG_SIZE_X, 32'hFFFFFFFF); write_reg(REG_SIZE_Y, 32'h7FFFFFFF);
    write_reg(REG_SIZE_Z, 32'h7FFFFFFF); write_reg(REG_FALLOFF, 32'h7FFFFFFF);
    send_sample(16'h7FFF, 16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h2);
    send_sample(16'h1234, 16'hF00D, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h2);
    drain_block();
    write_reg(REG_FALLOFF, 32'd1);
    send_sample(16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h1, 32'h2);
    drain_block();

    // Random phases, each with fresh settings.
    for (int ph = 0; ph < 9; ph++) begin
      write_reg(REG_MODE, $urandom_range(0, 7));
      write_reg(REG_CENTER_X, ($urandom_range(0, 4000) - 2000) * 32'sd65536 + $urandom_range(0, 65535));
      write_reg(REG_CENTER_Y, ($urandom_range(0, 4000) - 2000) * 32'sd65536 + $urandom_range(0, 65535));
      write_reg(REG_CENTER_Z, $urandom);
      write_reg(REG_SIZE_X, $urandom_range(66, 300 << 16));
      write_reg(REG_SIZE_Y, $urandom_range(66, 300 << 16));
      write_reg(REG_SIZE_Z, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(66, 300 << 16));
      write_reg(REG_FALLOFF, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 200 << 16));
      no_out_gaps = (ph % 3 == 2);
      for (int n = 0; n < 100; n++) send_random_sample();
      drain_block();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/dspm_pkg.sv
design/deep_sample_position_matte_top.sv
verif/testbench.sv
